FILE: src/aabb_cv_pkg.sv
// ----------------------------------------------------------------------------
// aabb_cv_pkg
// shared types and constants of the clip-space box visibility core
// ----------------------------------------------------------------------------
package aabb_cv_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned RowW       = 2;
  localparam int unsigned NumRows    = 4;
  localparam int unsigned NumCols    = 4;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned NumCorners = 8;
  localparam int unsigned CornerW    = 3;
  localparam int unsigned NumOps     = 6;
  localparam int unsigned FracW      = 16;
  localparam int unsigned ProdW      = 2 * DataW;
  localparam int unsigned ClipW      = 50;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // operand slots of a queued item
  localparam int unsigned OpMinX = 0;
  localparam int unsigned OpMinY = 1;
  localparam int unsigned OpMinZ = 2;
  localparam int unsigned OpMaxX = 3;
  localparam int unsigned OpMaxY = 4;
  localparam int unsigned OpMaxZ = 5;

  // clip vector components
  localparam int unsigned IdxX = 0;
  localparam int unsigned IdxY = 1;
  localparam int unsigned IdxZ = 2;
  localparam int unsigned IdxW = 3;

  typedef enum logic {
    FuncLoad = 1'b0,
    FuncTest = 1'b1
  } func_e;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [ClipW-1:0] clip_t;

  typedef struct packed {
    func_e                           func;
    logic [RowW-1:0]                 row;
    logic [NumOps-1:0][DataW-1:0]    data;
  } item_t;

endpackage

FILE: src/aabb_clip_space_visibility_test_core.sv
// a test result goes through the queue, the product, clip and result registers
// throughput: one corner per cycle through 12 multipliers unless the result stalls
// a matrix load leaves the queue without a corner walk and gives no result
// the two-entry input queue accepts while the back end works or its result waits
// reset (rst_ni low, asynchronous) zeroes the matrix and empties queue and pipeline
// ----------------------------------------------------------------------------
// aabb_clip_space_visibility_test_core
// box versus clip volume visibility test with a loadable 4x4 q16.16 matrix
// ----------------------------------------------------------------------------
module aabb_clip_space_visibility_test_core import aabb_cv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    func_i,
  input  logic [RowW-1:0]         row_index_i,
  input  logic signed [DataW-1:0] entry0_i,
  input  logic signed [DataW-1:0] entry1_i,
  input  logic signed [DataW-1:0] entry2_i,
  input  logic signed [DataW-1:0] entry3_i,
  input  logic signed [DataW-1:0] min_x_i,
  input  logic signed [DataW-1:0] min_y_i,
  input  logic signed [DataW-1:0] min_z_i,
  input  logic signed [DataW-1:0] max_x_i,
  input  logic signed [DataW-1:0] max_y_i,
  input  logic signed [DataW-1:0] max_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    visible_o
);

  logic  head_valid;
  item_t head;
  logic  pop;

  aabb_cv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .row_index_i  (row_index_i),
    .entry0_i     (entry0_i),
    .entry1_i     (entry1_i),
    .entry2_i     (entry2_i),
    .entry3_i     (entry3_i),
    .min_x_i      (min_x_i),
    .min_y_i      (min_y_i),
    .min_z_i      (min_z_i),
    .max_x_i      (max_x_i),
    .max_y_i      (max_y_i),
    .max_z_i      (max_z_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  aabb_cv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .visible_o    (visible_o)
  );

endmodule

FILE: src/aabb_cv_front.sv
// ----------------------------------------------------------------------------
// aabb_cv_front
// accepts transactions, sorts them into load and test items and queues them
// ----------------------------------------------------------------------------
module aabb_cv_front import aabb_cv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    func_i,
  input  logic [RowW-1:0]         row_index_i,
  input  logic signed [DataW-1:0] entry0_i,
  input  logic signed [DataW-1:0] entry1_i,
  input  logic signed [DataW-1:0] entry2_i,
  input  logic signed [DataW-1:0] entry3_i,
  input  logic signed [DataW-1:0] min_x_i,
  input  logic signed [DataW-1:0] min_y_i,
  input  logic signed [DataW-1:0] min_z_i,
  input  logic signed [DataW-1:0] max_x_i,
  input  logic signed [DataW-1:0] max_y_i,
  input  logic signed [DataW-1:0] max_z_i,
  output logic                    head_valid_o,
  output item_t                   head_o,
  input  logic                    pop_i
);

  item_t                 slot_q [QueueDepth];
  item_t                 new_item;
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  push;

  always_comb begin
    new_item      = '0;
    new_item.func = func_e'(func_i);
    new_item.row  = row_index_i;
    unique case (func_e'(func_i))
      FuncLoad: begin
        new_item.data[0] = entry0_i;
        new_item.data[1] = entry1_i;
        new_item.data[2] = entry2_i;
        new_item.data[3] = entry3_i;
      end
      FuncTest: begin
        new_item.data[OpMinX] = min_x_i;
        new_item.data[OpMinY] = min_y_i;
        new_item.data[OpMinZ] = min_z_i;
        new_item.data[OpMaxX] = max_x_i;
        new_item.data[OpMaxY] = max_y_i;
        new_item.data[OpMaxZ] = max_z_i;
      end
      default: new_item.data = '0;
    endcase
  end

  assign in_stall_o   = (cnt_q == QueueCntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_o && !pop_i) |=> (head_valid_o && $stable(head_o)))
    else $error("queue head changed before pop");

endmodule

FILE: src/aabb_cv_back.sv
// ----------------------------------------------------------------------------
// aabb_cv_back
// holds the matrix, walks the eight box corners and runs the clip test
// ----------------------------------------------------------------------------
module aabb_cv_back import aabb_cv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   head_valid_i,
  input  item_t  head_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output logic   visible_o
);

  word_t                   matrix_q [NumRows][NumCols];
  logic [CornerW-1:0]      corner_q;
  logic                    adv, is_load, is_test, last_corner, issue;
  word_t                   coord [NumAxes];

  logic signed [ProdW-1:0] prod_q [NumRows][NumAxes];
  word_t                   wcol_q [NumRows];
  logic                    s1_valid_q, s1_last_q;

  clip_t                   clip_d [NumRows];
  clip_t                   clip_q [NumRows];
  logic                    s2_valid_q, s2_last_q;

  clip_t                   w, nw, lo, hi, zlo, zhi;
  logic                    w_pos, in_clip;
  logic                    acc_q, out_valid_q, out_vis_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign is_load     = head_valid_i && (head_i.func == FuncLoad);
  assign is_test     = head_valid_i && (head_i.func == FuncTest);
  assign last_corner = (corner_q == CornerW'(NumCorners - 1));
  assign issue       = adv && is_test;
  assign pop_o       = adv && (is_load || (is_test && last_corner));

  // corner bit 2 picks x, bit 1 y, bit 0 z
  assign coord[IdxX] = corner_q[2] ? head_i.data[OpMaxX] : head_i.data[OpMinX];
  assign coord[IdxY] = corner_q[1] ? head_i.data[OpMaxY] : head_i.data[OpMinY];
  assign coord[IdxZ] = corner_q[0] ? head_i.data[OpMaxZ] : head_i.data[OpMinZ];

  // floor to q16.16 by arithmetic shift, then sum with the translation
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      clip_d[r] = ClipW'(prod_q[r][IdxX] >>> FracW)
                + ClipW'(prod_q[r][IdxY] >>> FracW)
                + ClipW'(prod_q[r][IdxZ] >>> FracW)
                + ClipW'(wcol_q[r]);
    end
  end

  // sign aware containment test
  always_comb begin
    w     = clip_q[IdxW];
    nw    = -w;
    w_pos = (w > 0);
    lo    = w_pos ? nw : w;
    hi    = w_pos ? w  : nw;
    zlo   = w_pos ? '0 : w;
    zhi   = w_pos ? w  : '0;
    in_clip = (w != 0)
           && (clip_q[IdxX] >= lo) && (clip_q[IdxX] <= hi)
           && (clip_q[IdxY] >= lo) && (clip_q[IdxY] <= hi)
           && (clip_q[IdxZ] >= zlo) && (clip_q[IdxZ] <= zhi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < NumCols; c++) begin
          matrix_q[r][c] <= '0;
        end
      end
      corner_q    <= '0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_vis_q   <= 1'b0;
    end else if (adv) begin
      if (is_load) begin
        for (int c = 0; c < NumCols; c++) begin
          matrix_q[head_i.row][c] <= head_i.data[c];
        end
      end
      if (issue) begin
        corner_q <= last_corner ? '0 : corner_q + 1'b1;
      end
      s1_valid_q  <= issue;
      s1_last_q   <= issue && last_corner;
      s2_valid_q  <= s1_valid_q;
      s2_last_q   <= s1_last_q;
      if (s2_valid_q) begin
        acc_q <= s2_last_q ? 1'b0 : (acc_q | in_clip);
      end
      out_valid_q <= s2_valid_q && s2_last_q;
      out_vis_q   <= acc_q | in_clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int a = 0; a < NumAxes; a++) begin
          prod_q[r][a] <= matrix_q[r][a] * coord[a];
        end
        wcol_q[r] <= matrix_q[r][IdxW];
        clip_q[r] <= clip_d[r];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;

  a_corner_on_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (corner_q != '0) |-> (head_valid_i && head_i.func == FuncTest))
    else $error("corner walk without a test item at queue head");

  a_freeze_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(s2_valid_q) && $stable(acc_q)))
    else $error("corner pipeline moved while result stalled");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(visible_o)))
    else $error("stalled result transaction changed");

endmodule
